>>> sv/tbtff_pkg.sv
package tbtff_pkg;

    // Table geometry.
    localparam int SLOTS = 1024;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [IDX_W-1:0] idx_t;

    // Operation codes.
    localparam logic [1:0] OP_MAP  = 2'd0;
    localparam logic [1:0] OP_REQ  = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADARG = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Region kind codes.
    localparam logic [3:0] KIND_EMPTY = 4'd0;
    localparam logic [3:0] KIND_AVAIL = 4'd1;
    localparam logic [3:0] KIND_BAD   = 4'd5;
    localparam logic [3:0] KIND_MAX   = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic start;
        logic scan;
        logic clr_wr;
        logic wr_dst;
        logic wr_src;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic bad_arg;
        logic need_write;
        logic is_req;
    } dp_stat_t;

endpackage

>>> sv/tbtff_dp.sv
module tbtff_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  tbtff_pkg::dp_cmd_t cmd,
    output tbtff_pkg::dp_stat_t stat,
    input  logic [1:0]         s_opcode,
    input  logic [31:0]        s_region_address,
    input  logic [31:0]        s_region_size,
    input  logic [3:0]         s_region_kind,
    output logic [1:0]         m_status,
    output logic [9:0]         m_slot_index,
    output logic [31:0]        m_found_address,
    output logic [31:0]        m_found_size,
    output logic [3:0]         m_found_kind
);
    import tbtff_pkg::*;

    // Slot table.
    logic [31:0] addr_mem [SLOTS];
    logic [31:0] size_mem [SLOTS];
    logic [3:0]  kind_mem [SLOTS];

    // Latched operation.
    logic [1:0]  op_reg;
    logic [31:0] in_addr_reg;
    logic [31:0] in_size_reg;
    logic [3:0]  in_kind_reg;

    // Scan pipeline.
    idx_t        rd_idx_reg;
    idx_t        ev_idx_reg;
    logic        ev_valid_reg;
    logic [31:0] ra_reg;
    logic [31:0] rs_reg;
    logic [3:0]  rk_reg;

    // Scan results.
    logic        dst_found_reg;
    idx_t        dst_idx_reg;
    logic [31:0] hit_addr_reg;
    logic [31:0] hit_size_reg;
    logic        src_found_reg;
    idx_t        src_idx_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] src_size_reg;

    // Result register.
    logic [1:0]  res_status_reg;
    logic [9:0]  res_index_reg;
    logic [31:0] res_addr_reg;
    logic [31:0] res_size_reg;
    logic [3:0]  res_kind_reg;

    logic        is_req;
    logic        bad_arg;
    logic [3:0]  tgt_kind;
    logic        tgt_now;
    logic        fit_now;
    logic        ev_last;
    logic        write_ok;

    logic        wr_en;
    idx_t        wr_idx;
    logic [31:0] wr_addr;
    logic [31:0] wr_size;
    logic [3:0]  wr_kind;

    logic [1:0]  res_status;
    idx_t        res_idx;
    logic [31:0] res_idx_wide;
    logic [31:0] res_addr;
    logic [31:0] res_size;
    logic [3:0]  res_kind;

    // Argument checks on the latched operation.
    always_comb begin
        is_req = (op_reg == OP_REQ);
        bad_arg = 1'b0;
        if (in_kind_reg > KIND_MAX) begin
            bad_arg = 1'b1;
        end else begin
            case (op_reg)
                OP_MAP:  bad_arg = (in_size_reg == 32'd0) || (in_kind_reg == KIND_EMPTY);
                OP_REQ:  bad_arg = (in_size_reg == 32'd0) || (in_kind_reg == KIND_EMPTY)
                                   || (in_kind_reg == KIND_BAD);
                OP_FIND: bad_arg = (in_kind_reg == KIND_EMPTY);
                default: bad_arg = 1'b1;
            endcase
        end
    end

    // Per-slot match logic on the registered read data.
    always_comb begin
        tgt_kind = (op_reg == OP_FIND) ? in_kind_reg : KIND_EMPTY;
        tgt_now  = ev_valid_reg && (rk_reg == tgt_kind);
        fit_now  = ev_valid_reg && (rk_reg == KIND_AVAIL) && (rs_reg >= in_size_reg);
        ev_last  = (ev_idx_reg == IDX_W'(SLOTS - 1));
    end

    // Status toward the controller.
    always_comb begin
        stat.bad_arg  = bad_arg;
        stat.is_req   = is_req;
        stat.clr_last = (rd_idx_reg == IDX_W'(SLOTS - 1));
        if (is_req) begin
            stat.scan_done = ev_valid_reg && (ev_last ||
                ((src_found_reg || fit_now) && (dst_found_reg || tgt_now)));
        end else begin
            stat.scan_done = ev_valid_reg && (ev_last || dst_found_reg || tgt_now);
        end
        write_ok = dst_found_reg && (!is_req || src_found_reg);
        stat.need_write = write_ok && (op_reg != OP_FIND);
    end

    // Scan counter and scan-result found flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            dst_found_reg <= 1'b0;
            src_found_reg <= 1'b0;
        end else begin
            ev_valid_reg <= cmd.scan;
            if (cmd.start) begin
                rd_idx_reg    <= '0;
                dst_found_reg <= 1'b0;
                src_found_reg <= 1'b0;
            end else if (cmd.scan || cmd.clr_wr) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.scan && !dst_found_reg && tgt_now) begin
                dst_found_reg <= 1'b1;
            end
            if (cmd.scan && is_req && !src_found_reg && fit_now) begin
                src_found_reg <= 1'b1;
            end
        end
    end

    // Payload side of the latch and scan results.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg      <= s_opcode;
            in_addr_reg <= s_region_address;
            in_size_reg <= s_region_size;
            in_kind_reg <= s_region_kind;
        end
        ev_idx_reg <= rd_idx_reg;
        if (cmd.scan && !dst_found_reg && tgt_now) begin
            dst_idx_reg  <= ev_idx_reg;
            hit_addr_reg <= ra_reg;
            hit_size_reg <= rs_reg;
        end
        if (cmd.scan && is_req && !src_found_reg && fit_now) begin
            src_idx_reg  <= ev_idx_reg;
            src_addr_reg <= ra_reg;
            src_size_reg <= rs_reg;
        end
    end

    // Write port selection: clearing pass, new slot, or shrunk source.
    always_comb begin
        wr_en   = cmd.clr_wr || cmd.wr_dst || cmd.wr_src;
        wr_idx  = rd_idx_reg;
        wr_addr = in_addr_reg;
        wr_size = in_size_reg;
        wr_kind = KIND_EMPTY;
        if (cmd.wr_dst) begin
            wr_idx  = dst_idx_reg;
            wr_addr = is_req ? src_addr_reg : in_addr_reg;
            wr_size = in_size_reg;
            wr_kind = in_kind_reg;
        end else if (cmd.wr_src) begin
            wr_idx  = src_idx_reg;
            wr_addr = src_addr_reg + in_size_reg;
            wr_size = src_size_reg - in_size_reg;
            wr_kind = KIND_AVAIL;
        end
    end

    // Table memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_mem[wr_idx] <= wr_kind;
            if (!cmd.clr_wr) begin
                addr_mem[wr_idx] <= wr_addr;
                size_mem[wr_idx] <= wr_size;
            end
        end
        ra_reg <= addr_mem[rd_idx_reg];
        rs_reg <= size_mem[rd_idx_reg];
        rk_reg <= kind_mem[rd_idx_reg];
    end

    // Result selection.
    always_comb begin
        res_status = ST_OK;
        res_idx    = dst_idx_reg;
        res_addr   = in_addr_reg;
        res_size   = in_size_reg;
        res_kind   = in_kind_reg;
        if (bad_arg) begin
            res_status = ST_BADARG;
        end else begin
            case (op_reg)
                OP_MAP: begin
                    if (!dst_found_reg) begin
                        res_status = ST_FULL;
                    end
                end
                OP_REQ: begin
                    res_addr = src_addr_reg;
                    if (!src_found_reg) begin
                        res_status = ST_NONE;
                    end else if (!dst_found_reg) begin
                        res_status = ST_FULL;
                    end
                end
                OP_FIND: begin
                    res_addr = hit_addr_reg;
                    res_size = hit_size_reg;
                    if (!dst_found_reg) begin
                        res_status = ST_NONE;
                    end
                end
                default: res_status = ST_BADARG;
            endcase
        end
        res_idx_wide = 32'(res_idx);
    end

    // Output register; failed operations report zero fields.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            res_status_reg <= res_status;
            if (res_status == ST_OK) begin
                res_index_reg <= res_idx_wide[9:0];
                res_addr_reg  <= res_addr;
                res_size_reg  <= res_size;
                res_kind_reg  <= res_kind;
            end else begin
                res_index_reg <= '0;
                res_addr_reg  <= '0;
                res_size_reg  <= '0;
                res_kind_reg  <= '0;
            end
        end
    end

    assign m_status        = res_status_reg;
    assign m_slot_index    = res_index_reg;
    assign m_found_address = res_addr_reg;
    assign m_found_size    = res_size_reg;
    assign m_found_kind    = res_kind_reg;

endmodule

>>> sv/tbtff_ctrl.sv
module tbtff_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tbtff_pkg::dp_cmd_t  cmd,
    input  tbtff_pkg::dp_stat_t stat
);
    import tbtff_pkg::*;

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        CHECK,
        SCAN,
        POST,
        WR_DST,
        WR_SRC,
        FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;

    // Commands decoded from the current state.
    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == IDLE) && s_valid;
        cmd.start    = (state_reg == CHECK);
        cmd.scan     = (state_reg == SCAN);
        cmd.clr_wr   = (state_reg == CLEAR);
        cmd.wr_dst   = (state_reg == WR_DST);
        cmd.wr_src   = (state_reg == WR_SRC);
        cmd.load_out = (state_reg == FINISH) && out_free;
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                CLEAR: begin
                    if (stat.clr_last) begin
                        state_reg <= IDLE;
                    end
                end
                IDLE: begin
                    if (s_valid) begin
                        state_reg <= CHECK;
                    end
                end
                CHECK: begin
                    state_reg <= stat.bad_arg ? FINISH : SCAN;
                end
                SCAN: begin
                    if (stat.scan_done) begin
                        state_reg <= POST;
                    end
                end
                POST: begin
                    state_reg <= stat.need_write ? WR_DST : FINISH;
                end
                WR_DST: begin
                    state_reg <= stat.is_req ? WR_SRC : FINISH;
                end
                WR_SRC: begin
                    state_reg <= FINISH;
                end
                FINISH: begin
                    if (out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

>>> sv/typed_block_table_first_fit.sv
// An invalid argument is answered without a scan; any other
// operation scans the table one slot per cycle through the registered memory read port.
// One operation at a time; the next input transfer can be taken in the cycle after
// the result is loaded.
// Reset is synchronous, active low; the kind table is then cleared slot by slot, s_ready low.
module typed_block_table_first_fit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_region_address,
    input  logic [31:0] s_region_size,
    input  logic [3:0]  s_region_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_slot_index,
    output logic [31:0] m_found_address,
    output logic [31:0] m_found_size,
    output logic [3:0]  m_found_kind
);
    import tbtff_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    tbtff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Slot table, scan logic and result register.
    tbtff_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_region_address (s_region_address),
        .s_region_size    (s_region_size),
        .s_region_kind    (s_region_kind),
        .m_status         (m_status),
        .m_slot_index     (m_slot_index),
        .m_found_address  (m_found_address),
        .m_found_size     (m_found_size),
        .m_found_kind     (m_found_kind)
    );

endmodule

>>> sv/tbtff_checker.sv
module tbtff_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [9:0]  m_slot_index,
    input logic [31:0] m_found_address,
    input logic [31:0] m_found_size,
    input logic [3:0]  m_found_kind
);
    import tbtff_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_index))
        else $error("result changed while stalled");

    // A failed operation reports zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_slot_index == 10'd0) &&
        (m_found_address == 32'd0) && (m_found_size == 32'd0) && (m_found_kind == 4'd0))
        else $error("nonzero fields on failed operation");

    // A successful result always names an occupied, legal kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OK) |-> (m_found_kind != KIND_EMPTY) &&
        (m_found_kind <= KIND_MAX))
        else $error("success with empty or illegal kind");

    // Only one operation is in flight: ready drops right after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input taken during an operation");

    // The clearing pass keeps the input closed right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during table clear");

endmodule

bind typed_block_table_first_fit tbtff_checker u_tbtff_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_slot_index    (m_slot_index),
    .m_found_address (m_found_address),
    .m_found_size    (m_found_size),
    .m_found_kind    (m_found_kind)
);
